### src/sau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sau_pkg
// Shared constants, types and tables for the sigmoid activation pipeline.
// ----------------------------------------------------------------------------
package sau_pkg;

    // input sample format
    localparam int IN_W         = 16;
    localparam int IN_FRAC_BITS = 12;

    // working fixed point format for exp(-a), Q2.30
    localparam int WORK_FRAC    = 30;
    localparam int SERIES_TERMS = 12;

    // magnitude of the input, |x| <= 32768 fits unsigned 16 bits
    localparam int A_W   = 16;
    // a scaled to Q.30
    localparam int Y30_W = A_W + WORK_FRAC - IN_FRAC_BITS;
    // reduced argument r < ln2 in Q2.30
    localparam int R_W   = 30;
    // series term and running sum, both at most 1.0 in Q2.30
    localparam int TERM_W = 31;
    localparam int SUM_W  = 31;

    // ln(2) in Q2.30, rounded
    localparam logic [R_W-1:0] LN2_Q30 = 30'd744261118;

    // largest multiple count of ln2 inside |x| <= 8.0
    localparam int N_MAX = 11;
    localparam int N_W   = 4;

    // item bookkeeping that travels along the pipeline
    typedef struct packed {
        logic           neg;
        logic           last;
        logic [N_W-1:0] n;
    } t_side;

    // j * ln2 in Q.30
    function automatic logic [Y30_W-1:0] ln2_mult(input logic [N_W-1:0] j);
        ln2_mult = Y30_W'(j) * Y30_W'(LN2_Q30);
    endfunction

endpackage
`default_nettype wire

### src/sigmoid_activation_unit.sv
// throughput: one sample per cycle; the whole pipeline advances whenever the
//   output register is empty or its result is taken in the same cycle
// the depth is set by the twelve three-stage series terms and the
//   one-bit-per-stage reciprocal divider
// reset clears the valid bits only; no other state
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigmoid_activation_unit
// Streaming logistic sigmoid, signed Q4.12 in, unsigned Q0.OUT_WIDTH out.
// ----------------------------------------------------------------------------
module sigmoid_activation_unit
    import sau_pkg::*;
#(
    parameter int OUT_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic signed [IN_W-1:0] i_x_in,
    input  wire logic                   i_last_in,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    output logic [OUT_WIDTH-1:0]        o_y_out,
    output logic                        o_last_out,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready
);

    logic w_en;
    logic w_out_valid;

    logic              w_valid [SERIES_TERMS+1];
    t_side             w_side  [SERIES_TERMS+1];
    logic [R_W-1:0]    w_r     [SERIES_TERMS+1];
    logic [TERM_W-1:0] w_term  [SERIES_TERMS+1];
    logic [SUM_W-1:0]  w_sum   [SERIES_TERMS+1];

    // global advance: output slot free or being drained
    assign w_en       = !w_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // range reduction
    sau_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_x     (i_x_in),
        .i_last  (i_last_in),
        .o_valid (w_valid[0]),
        .o_side  (w_side[0]),
        .o_r     (w_r[0])
    );

    // series starts at 1.0 for both term and sum
    assign w_term[0] = TERM_W'(1) << WORK_FRAC;
    assign w_sum[0]  = SUM_W'(1) << WORK_FRAC;

    // taylor series of exp(-r), one unit per term
    for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
        sau_term #(
            .K (k)
        ) u_term (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k-1]),
            .i_side  (w_side[k-1]),
            .i_r     (w_r[k-1]),
            .i_term  (w_term[k-1]),
            .i_sum   (w_sum[k-1]),
            .o_valid (w_valid[k]),
            .o_side  (w_side[k]),
            .o_r     (w_r[k]),
            .o_term  (w_term[k]),
            .o_sum   (w_sum[k])
        );
    end

    // reciprocal, sign fold and output register
    sau_recip #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_valid[SERIES_TERMS]),
        .i_side  (w_side[SERIES_TERMS]),
        .i_sum   (w_sum[SERIES_TERMS]),
        .o_valid (w_out_valid),
        .o_y     (o_y_out),
        .o_last  (o_last_out)
    );

    assign o_out_valid = w_out_valid;

endmodule
`default_nettype wire

### src/sau_range.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sau_range
// Takes |x| and splits it as n*ln2 + r with 0 <= r < ln2, two stages.
// ----------------------------------------------------------------------------
module sau_range
    import sau_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic signed [IN_W-1:0] i_x,
    input  wire logic                  i_last,
    output logic                       o_valid,
    output t_side                      o_side,
    output logic [R_W-1:0]             o_r
);

    logic [IN_W-1:0]  w_xu;
    logic             w_neg;
    logic [A_W-1:0]   w_abs;
    logic [Y30_W-1:0] w_y30;
    logic [N_MAX-1:0] w_ge;

    logic             r_s1_valid;
    logic [N_MAX-1:0] r_s1_ge;
    logic [Y30_W-1:0] r_s1_y30;
    logic             r_s1_neg;
    logic             r_s1_last;

    logic [N_W-1:0]   w_n;
    logic [Y30_W-1:0] w_rem;

    logic             r_s2_valid;
    t_side            r_s2_side;
    logic [R_W-1:0]   r_s2_r;

    // magnitude and thermometer compare against multiples of ln2
    always_comb begin
        w_xu  = IN_W'(i_x);
        w_neg = w_xu[IN_W-1];
        w_abs = w_neg ? A_W'(~w_xu + IN_W'(1)) : A_W'(w_xu);
        w_y30 = Y30_W'(w_abs) << (WORK_FRAC - IN_FRAC_BITS);
        for (int j = 0; j < N_MAX; j++) begin
            w_ge[j] = (w_y30 >= ln2_mult(N_W'(j + 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_ge   <= w_ge;
            r_s1_y30  <= w_y30;
            r_s1_neg  <= w_neg;
            r_s1_last <= i_last;
        end
    end

    // n is the count of thresholds passed, r the leftover
    always_comb begin
        w_n   = N_W'($countones(r_s1_ge));
        w_rem = r_s1_y30 - ln2_mult(w_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_side.neg  <= r_s1_neg;
            r_s2_side.last <= r_s1_last;
            r_s2_side.n    <= w_n;
            r_s2_r         <= R_W'(w_rem);
        end
    end

    assign o_valid = r_s2_valid;
    assign o_side  = r_s2_side;
    assign o_r     = r_s2_r;

endmodule
`default_nettype wire

### src/sau_term.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sau_term
// One Taylor term of exp(-r): term = ((term * r) >> 30) / K, then the
// running sum takes it with alternating sign. Three stages.
// ----------------------------------------------------------------------------
module sau_term
    import sau_pkg::*;
#(
    parameter int K = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_side             i_side,
    input  wire logic [R_W-1:0]    i_r,
    input  wire logic [TERM_W-1:0] i_term,
    input  wire logic [SUM_W-1:0]  i_sum,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic [R_W-1:0]         o_r,
    output logic [TERM_W-1:0]      o_term,
    output logic [SUM_W-1:0]       o_sum
);

    // floor(2^32 / K); truncated quotient is exact or one low
    localparam int         MAG_W = 33;
    localparam logic [MAG_W-1:0] MAGIC = MAG_W'(64'd4294967296 / K);
    localparam int         K_W   = $clog2(K + 1);
    localparam logic [K_W-1:0] K_C = K_W'(K);
    localparam bit         ODD   = ((K % 2) == 1);
    localparam int         PA_W  = TERM_W + R_W;
    localparam int         PB_W  = R_W + MAG_W;

    logic [PA_W-1:0] w_prod_a;
    logic            r_a_valid;
    t_side           r_a_side;
    logic [R_W-1:0]  r_a_r;
    logic [SUM_W-1:0] r_a_sum;
    logic [R_W-1:0]  r_a_p;

    logic [PB_W-1:0] w_prod_b;
    logic            r_b_valid;
    t_side           r_b_side;
    logic [R_W-1:0]  r_b_r;
    logic [SUM_W-1:0] r_b_sum;
    logic [R_W-1:0]  r_b_p;
    logic [R_W-1:0]  r_b_qa;

    logic [R_W-1:0]  w_qk;
    logic [R_W-1:0]  w_rem;
    logic [R_W-1:0]  w_q;
    logic [SUM_W-1:0] w_sum;

    logic            r_c_valid;
    t_side           r_c_side;
    logic [R_W-1:0]  r_c_r;
    logic [SUM_W-1:0] r_c_sum;
    logic [R_W-1:0]  r_c_q;

    // stage a: product with r, back to Q2.30
    assign w_prod_a = PA_W'(i_term) * PA_W'(i_r);

    // stage b: reciprocal multiply for the division by K
    assign w_prod_b = PB_W'(r_a_p) * PB_W'(MAGIC);

    // stage c: one-step correction and sum update
    always_comb begin
        w_qk  = r_b_qa * R_W'(K_C);
        w_rem = r_b_p - w_qk;
        w_q   = (w_rem >= R_W'(K_C)) ? (r_b_qa + R_W'(1)) : r_b_qa;
        if (ODD) begin
            w_sum = r_b_sum - SUM_W'(w_q);
        end else begin
            w_sum = r_b_sum + SUM_W'(w_q);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // data path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_a_r    <= i_r;
            r_a_sum  <= i_sum;
            r_a_p    <= w_prod_a[WORK_FRAC +: R_W];

            r_b_side <= r_a_side;
            r_b_r    <= r_a_r;
            r_b_sum  <= r_a_sum;
            r_b_p    <= r_a_p;
            r_b_qa   <= w_prod_b[32 +: R_W];

            r_c_side <= r_b_side;
            r_c_r    <= r_b_r;
            r_c_sum  <= w_sum;
            r_c_q    <= w_q;
        end
    end

    assign o_valid = r_c_valid;
    assign o_side  = r_c_side;
    assign o_r     = r_c_r;
    assign o_term  = TERM_W'(r_c_q);
    assign o_sum   = r_c_sum;

endmodule
`default_nettype wire

### src/sau_recip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sau_recip
// Scales exp(-r) by 2^-n, forms round(2^(W+30) / (2^30 + e)) by a restoring
// divider of one quotient bit per stage, then picks t or 1 - t.
// ----------------------------------------------------------------------------
module sau_recip
    import sau_pkg::*;
#(
    parameter int OUT_WIDTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire t_side            i_side,
    input  wire logic [SUM_W-1:0] i_sum,
    output logic                  o_valid,
    output logic [OUT_WIDTH-1:0]  o_y,
    output logic                  o_last
);

    localparam int Q_W   = OUT_WIDTH + 1;
    localparam int D_W   = WORK_FRAC + 2;
    localparam int REM_W = WORK_FRAC + 1;

    logic [SUM_W-1:0] w_e;
    logic [D_W-1:0]   w_d;
    logic [REM_W-1:0] w_nhi;

    // index 0 is the setup stage, index g the g-th quotient bit
    logic             r_valid [Q_W+1];
    t_side            r_side  [Q_W+1];
    logic [REM_W-1:0] r_rem   [Q_W+1];
    logic [Q_W-1:0]   r_q     [Q_W+1];
    logic [D_W-1:0]   r_d     [Q_W];
    logic [Q_W-1:0]   r_lo    [Q_W];

    logic [Q_W-1:0]       w_tq;
    logic [Q_W-1:0]       w_full;
    logic [OUT_WIDTH-1:0] w_y;

    logic                 r_out_valid;
    logic [OUT_WIDTH-1:0] r_out_y;
    logic                 r_out_last;

    // setup: divisor, upper numerator part as first remainder, low bits
    always_comb begin
        w_e   = i_sum >> i_side.n;
        w_d   = (D_W'(1) << WORK_FRAC) + D_W'(w_e);
        w_nhi = REM_W'((D_W'(1) << (WORK_FRAC - 1)) + (w_d >> (OUT_WIDTH + 2)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rem[0]  <= w_nhi;
            r_q[0]    <= '0;
            r_d[0]    <= w_d;
            r_lo[0]   <= w_d[Q_W:1];
        end
    end

    // divider stages, most significant quotient bit first
    for (genvar g = 1; g <= Q_W; g++) begin : g_div
        logic [D_W-1:0] w_shift;
        logic           w_take;

        always_comb begin
            w_shift = {r_rem[g-1], r_lo[g-1][Q_W-g]};
            w_take  = (w_shift >= r_d[g-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= r_valid[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g] <= r_side[g-1];
                r_rem[g]  <= w_take ? REM_W'(w_shift - r_d[g-1]) : REM_W'(w_shift);
                r_q[g]    <= {r_q[g-1][Q_W-2:0], w_take};
            end
        end

        if (g < Q_W) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[g]  <= r_d[g-1];
                    r_lo[g] <= r_lo[g-1];
                end
            end
        end
    end

    // sign fold and saturation of exactly one
    always_comb begin
        w_tq   = r_q[Q_W];
        w_full = Q_W'(1) << OUT_WIDTH;
        if (r_side[Q_W].neg) begin
            w_y = OUT_WIDTH'(w_full - w_tq);
        end else if (w_tq[OUT_WIDTH]) begin
            w_y = '1;
        end else begin
            w_y = w_tq[OUT_WIDTH-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_y    <= w_y;
            r_out_last <= r_side[Q_W].last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_y     = r_out_y;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire
